>>> sv/dtse_pkg.sv
package dtse_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_LEAD,
        PH_NUM,
        PH_FRAC,
        PH_TRAIL,
        PH_ERR
    } phase_t;

    localparam int MagWidth = 60;
    localparam int SigWidth = 61;
    localparam int ExpWidth = 16;
    localparam int CntWidth = 5;

    localparam logic [CntWidth-1:0] DigitCap      = 5'd18;
    localparam logic [CntWidth-1:0] DigitsDefault = 5'd9;
    localparam logic [ExpWidth-1:0] ExpMax        = 16'h7FFF;

    localparam logic [7:0] CharNul   = 8'h00;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [7:0] CharPoint = 8'h2E;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharCr    = 8'h0D;
    localparam logic [7:0] CharSpace = 8'h20;

    // Running state of one number being parsed.
    typedef struct packed {
        phase_t                phase;
        logic [MagWidth-1:0]   mag;
        logic                  neg;
        logic [CntWidth-1:0]   count;
        logic [ExpWidth-1:0]   exp;
        logic                  point;
    } dtse_state_t;

    // Result of one string.
    typedef struct packed {
        logic [SigWidth-1:0] sig;
        logic [ExpWidth-1:0] exp;
        logic                status;
    } dtse_result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CharSpace) || (c >= CharTab && c <= CharCr);
    endfunction

endpackage

>>> sv/dtse_step.sv
module dtse_step (
    input  dtse_pkg::dtse_state_t  st,
    input  logic [7:0]             char_code,
    input  logic [4:0]             budget,
    output dtse_pkg::dtse_state_t  st_next,
    output dtse_pkg::dtse_result_t result,
    output logic                   term
);
    import dtse_pkg::*;

    logic                digit;
    logic [3:0]          digit_val;
    logic                keep;
    logic                take;
    logic [63:0]         mag_times_ten;
    logic                bad;
    logic [SigWidth-1:0] mag_ext;

    // Character classes.
    assign term      = (char_code == CharNul);
    assign digit     = (char_code >= CharZero) && (char_code <= CharNine);
    assign digit_val = 4'(char_code - CharZero);
    assign keep      = st.count < budget;
    assign take      = digit && (st.phase == PH_LEAD || st.phase == PH_NUM
                                 || st.phase == PH_FRAC);
    assign mag_times_ten = {1'b0, st.mag, 3'b000} + {3'b000, st.mag, 1'b0}
                           + {60'd0, digit_val};

    // Phase transitions.
    always_comb
    begin
        st_next.phase = st.phase;
        if (term)
        begin
            st_next.phase = PH_LEAD;
        end
        else
        begin
            case (st.phase)
                PH_LEAD:
                begin
                    if (is_blank(char_code))
                        st_next.phase = PH_LEAD;
                    else if (char_code == CharMinus || char_code == CharPlus)
                        st_next.phase = PH_NUM;
                    else if (char_code == CharPoint)
                        st_next.phase = PH_FRAC;
                    else if (digit)
                        st_next.phase = PH_NUM;
                    else
                        st_next.phase = PH_ERR;
                end
                PH_NUM, PH_FRAC:
                begin
                    if (digit)
                        st_next.phase = st.phase;
                    else if (char_code == CharPoint && !st.point)
                        st_next.phase = PH_FRAC;
                    else if (is_blank(char_code))
                        st_next.phase = PH_TRAIL;
                    else
                        st_next.phase = PH_ERR;
                end
                PH_TRAIL:
                begin
                    if (!is_blank(char_code))
                        st_next.phase = PH_ERR;
                end
                default:
                begin
                    st_next.phase = PH_ERR;
                end
            endcase
        end

        // Accumulators: sign, point, kept digits and exponent.
        st_next.mag   = st.mag;
        st_next.neg   = st.neg;
        st_next.count = st.count;
        st_next.exp   = st.exp;
        st_next.point = st.point;
        if (term)
        begin
            st_next.mag   = '0;
            st_next.neg   = 1'b0;
            st_next.count = '0;
            st_next.exp   = '0;
            st_next.point = 1'b0;
        end
        else
        begin
            if (st.phase == PH_LEAD && (char_code == CharMinus || char_code == CharPlus))
                st_next.neg = (char_code == CharMinus);
            if (char_code == CharPoint && !st.point
                && (st.phase == PH_LEAD || st.phase == PH_NUM || st.phase == PH_FRAC))
                st_next.point = 1'b1;
            if (take)
            begin
                if (keep)
                begin
                    st_next.mag   = mag_times_ten[MagWidth-1:0];
                    st_next.count = st.count + 5'd1;
                    if (st.point)
                        st_next.exp = st.exp - 16'd1;
                end
                else if (!st.point && st.exp != ExpMax)
                begin
                    st_next.exp = st.exp + 16'd1;
                end
            end
        end
    end

    // Result formed from the state before the terminator.
    assign bad     = (st.phase == PH_ERR) || (st.count == '0);
    assign mag_ext = {1'b0, st.mag};

    always_comb
    begin
        if (bad)
        begin
            result.sig    = '0;
            result.exp    = '0;
            result.status = 1'b1;
        end
        else
        begin
            result.sig    = st.neg ? (-mag_ext) : mag_ext;
            result.exp    = st.exp;
            result.status = 1'b0;
        end
    end

endmodule

>>> sv/decimal_text_to_sig_exp.sv
// Decimal text parser: characters enter one per request on the input channel and a
// zero byte ends the string, which yields one result of significand, power-of-ten
// exponent and status (1 on a parse error, with significand and exponent zero).
// Each character is held in the input register while the next-state logic
// (one multiply-by-ten-and-add on the 60-bit magnitude) updates the parse state,
// so one character is taken every cycle but for one stall: a terminator that finds
// the result register still full and not being taken; it then waits in the input
// register until the result leaves. The digit budget is written on the config
// channel (reset 9, values above 18 act as 18) and should change only while idle.
module decimal_text_to_sig_exp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [60:0] sig_value,
    output logic signed [15:0] exp_value,
    output logic        status
);
    import dtse_pkg::*;

    logic [4:0]   max_digits_reg;
    logic [4:0]   budget;
    logic         in_valid_reg;
    logic [7:0]   char_reg;
    dtse_state_t  st_reg;
    dtse_state_t  st_next;
    dtse_result_t result;
    dtse_result_t res_reg;
    logic         out_valid_reg;
    logic         term;
    logic         consume;
    logic         load_out;

    // Configuration register.
    assign cfg_ready = 1'b1;
    assign budget    = (max_digits_reg > DigitCap) ? DigitCap : max_digits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_digits_reg <= DigitsDefault;
        else if (cfg_valid && cfg_ready)
            max_digits_reg <= cfg_data;
    end

    dtse_step u_step (
        .st        (st_reg),
        .char_code (char_reg),
        .budget    (budget),
        .st_next   (st_next),
        .result    (result),
        .term      (term)
    );

    // Flow control between input register, parse state and result register.
    assign consume  = in_valid_reg && (!term || !out_valid_reg || out_ready);
    assign load_out = consume && term;
    assign in_ready = !in_valid_reg || consume;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            char_reg <= char_code;
    end

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase <= PH_LEAD;
            st_reg.mag   <= '0;
            st_reg.neg   <= 1'b0;
            st_reg.count <= '0;
            st_reg.exp   <= '0;
            st_reg.point <= 1'b0;
        end
        else if (consume)
        begin
            st_reg <= st_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            res_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign sig_value = res_reg.sig;
    assign exp_value = res_reg.exp;
    assign status    = res_reg.status;

    // Checks.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.status |-> res_reg.sig == '0 && res_reg.exp == '0)
        else $error("error result carries nonzero payload");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.count <= DigitCap)
        else $error("kept digit count exceeds cap");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && term && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked terminator");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> st_reg.phase == PH_LEAD && st_reg.count == '0 && out_valid_reg)
        else $error("terminator did not clear state and post result");

endmodule

>>> sim/decimal_parse_monitor.sv
module decimal_parse_monitor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [7:0]                   char_code,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [4:0]                   cfg_data,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [dtse_pkg::SigWidth-1:0] sig_value,
    input  logic [dtse_pkg::ExpWidth-1:0] exp_value,
    input  logic                         status,
    output int                           mismatch_count,
    output int                           results_pending,
    output int                           results_checked,
    output int                           error_results
);
    import dtse_pkg::*;

    // Shadow copy of the parse state and of the digit budget.
    phase_t                     parse_phase;
    logic [MagWidth-1:0]        mag_acc;
    logic                       neg_seen;
    logic [CntWidth-1:0]        kept_digits;
    logic signed [ExpWidth-1:0] pow_acc;
    logic                       point_taken;
    logic [CntWidth-1:0]        digit_budget;

    // Results still owed by the block, oldest first.
    dtse_result_t results_due[$];

    int fail_tally;
    int checked_tally;
    int error_tally;

    function automatic logic white_char(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic clear_parse();
        parse_phase = PH_LEAD;
        mag_acc     = '0;
        neg_seen    = 1'b0;
        kept_digits = '0;
        pow_acc     = '0;
        point_taken = 1'b0;
    endtask

    // A digit is kept while the budget lasts; later integer digits scale the
    // exponent up (saturating) and later fraction digits are dropped.
    task automatic absorb_digit(input logic [3:0] d);
        logic [CntWidth-1:0] limit;
        limit = (digit_budget > DigitCap) ? DigitCap : digit_budget;
        if (kept_digits < limit)
        begin
            mag_acc = mag_acc * MagWidth'(10) + MagWidth'(d);
            kept_digits = kept_digits + 1'b1;
            if (point_taken)
                pow_acc = pow_acc - 16'sd1;
        end
        else if (!point_taken && pow_acc != ExpMax)
        begin
            pow_acc = pow_acc + 16'sd1;
        end
    endtask

    // Advance the parse by one character; a zero byte closes the string.
    task automatic step_parse(input logic [7:0] c);
        dtse_result_t res;
        logic         is_digit;
        is_digit = (c >= CharZero) && (c <= CharNine);
        if (c == CharNul)
        begin
            if (parse_phase == PH_ERR || kept_digits == 0)
            begin
                res.sig    = '0;
                res.exp    = '0;
                res.status = 1'b1;
            end
            else
            begin
                res.sig = {1'b0, mag_acc};
                if (neg_seen)
                    res.sig = -res.sig;
                res.exp    = pow_acc;
                res.status = 1'b0;
            end
            results_due.push_back(res);
            clear_parse();
        end
        else
        begin
            case (parse_phase)
                PH_LEAD:
                begin
                    if (white_char(c))
                    begin
                    end
                    else if (c == CharMinus || c == CharPlus)
                    begin
                        neg_seen = (c == CharMinus);
                        parse_phase = PH_NUM;
                    end
                    else if (c == CharPoint)
                    begin
                        point_taken = 1'b1;
                        parse_phase = PH_FRAC;
                    end
                    else if (is_digit)
                    begin
                        absorb_digit(4'(c - CharZero));
                        parse_phase = PH_NUM;
                    end
                    else
                    begin
                        parse_phase = PH_ERR;
                    end
                end
                PH_NUM, PH_FRAC:
                begin
                    if (is_digit)
                        absorb_digit(4'(c - CharZero));
                    else if (c == CharPoint && !point_taken)
                    begin
                        point_taken = 1'b1;
                        parse_phase = PH_FRAC;
                    end
                    else if (white_char(c))
                        parse_phase = PH_TRAIL;
                    else
                        parse_phase = PH_ERR;
                end
                PH_TRAIL:
                begin
                    if (!white_char(c))
                        parse_phase = PH_ERR;
                end
                default:
                begin
                    parse_phase = PH_ERR;
                end
            endcase
        end
    endtask

    // Compare one delivered result against the oldest one owed.
    task automatic check_result();
        dtse_result_t want;
        if (results_due.size() == 0)
        begin
            $display("%0t: result with none expected: sig %0d exp %0d status %0b",
                     $time, $signed(sig_value), $signed(exp_value), status);
            fail_tally++;
        end
        else
        begin
            want = results_due.pop_front();
            checked_tally++;
            if (want.status)
                error_tally++;
            if (sig_value !== want.sig)
            begin
                $display("%0t: sig_value mismatch, expected %0d, actual %0d",
                         $time, $signed(want.sig), $signed(sig_value));
                fail_tally++;
            end
            if (exp_value !== want.exp)
            begin
                $display("%0t: exp_value mismatch, expected %0d, actual %0d",
                         $time, $signed(want.exp), $signed(exp_value));
                fail_tally++;
            end
            if (status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0b, actual %0b",
                         $time, want.status, status);
                fail_tally++;
            end
        end
    endtask

    // Everything is sampled at the clock edge, before the driven inputs move.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            digit_budget = DigitsDefault;
            results_due.delete();
            fail_tally = 0;
            checked_tally = 0;
            error_tally = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
                digit_budget = cfg_data;
            if (in_valid && in_ready)
                step_parse(char_code);
        end
        mismatch_count  <= fail_tally;
        results_pending <= results_due.size();
        results_checked <= checked_tally;
        error_results   <= error_tally;
    end

endmodule

>>> sim/decimal_text_to_sig_exp_test.sv
module decimal_text_to_sig_exp_test;
    import dtse_pkg::*;

    localparam int HalfPeriod     = 10;
    localparam int ResetCycles    = 6;
    localparam int IdleLimit      = 4000;
    localparam int LongHoldCycles = 80;
    localparam int DrainCycles    = 4;
    localparam int SettleCycles   = 20;
    localparam int PhaseChars     = 230;
    localparam int PhaseCount     = 8;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [7:0]          char_code = CharNul;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [4:0]          cfg_data  = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [60:0]  sig_value;
    logic signed [15:0]  exp_value;
    logic                status;

    int mismatch_count;
    int results_pending;
    int results_checked;
    int error_results;

    // Sender state.
    logic [7:0] line_buf[$];
    int         burst_left = 0;
    logic       no_gaps    = 1'b0;
    int         chars_sent = 0;

    // Receiver state; hold_token asks the receiver for one long hold-off.
    int hold_token   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int ready_pct    = 100;
    int pattern_left = 0;

    int idle_cycles = 0;

    decimal_text_to_sig_exp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sig_value (sig_value),
        .exp_value (exp_value),
        .status    (status)
    );

    decimal_parse_monitor monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_code       (char_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sig_value       (sig_value),
        .exp_value       (exp_value),
        .status          (status),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked),
        .error_results   (error_results)
    );

    always #HalfPeriod clk = ~clk;

    // Receiver: random ready patterns, all-ready stretches, and one long hold-off.
    always @(posedge clk)
    begin
        if (hold_seen != hold_token)
        begin
            hold_seen <= hold_token;
            hold_left <= LongHoldCycles;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_left <= $urandom_range(4, 60);
                case ($urandom_range(0, 3))
                    0: ready_pct <= 100;
                    1: ready_pct <= 75;
                    2: ready_pct <= 40;
                    default: ready_pct <= 10;
                endcase
            end
            else
            begin
                pattern_left <= pattern_left - 1;
            end
            out_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Watchdog: too long without any request moving ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IdleLimit)
        begin
            $display("%0t: timeout, no request moved for %0d cycles", $time, IdleLimit);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one character, opening a new burst after a random gap when due.
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0 && !no_gaps)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        char_code <= c;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left != 0)
            burst_left--;
        chars_sent++;
    endtask

    // Send the buffered text followed by the terminating zero byte.
    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i]);
        send_char(CharNul);
        line_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Stop offering and wait until every owed result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        repeat (DrainCycles) @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_budget(input logic [4:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CharSpace : 8'(CharTab + k);
    endfunction

    // Mostly short digit runs, now and then long enough to overrun the budget.
    function automatic int pick_run_length();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5);
    endfunction

    task automatic push_digits(input int n, input logic nines);
        repeat (n)
        begin
            if (nines)
                line_buf.push_back(CharNine);
            else
                line_buf.push_back(8'(CharZero + $urandom_range(0, 9)));
        end
    endtask

    // Number text: blanks, optional sign, digits, optional fraction, blanks.
    task automatic build_number();
        logic nines;
        nines = ($urandom_range(0, 7) == 0);
        repeat ($urandom_range(0, 2)) line_buf.push_back(random_blank());
        case ($urandom_range(0, 3))
            0: line_buf.push_back(CharMinus);
            1: line_buf.push_back(CharPlus);
            default: ;
        endcase
        push_digits(pick_run_length(), nines);
        if ($urandom_range(0, 1) == 1)
        begin
            line_buf.push_back(CharPoint);
            push_digits(pick_run_length(), nines);
        end
        repeat ($urandom_range(0, 2)) line_buf.push_back(random_blank());
    endtask

    // Mix of clean numbers, numbers with one damaged character, and raw noise.
    task automatic build_random_line();
        int         kind;
        int         pos;
        logic [7:0] junk;
        kind = $urandom_range(0, 19);
        if (kind < 3)
        begin
            repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            build_number();
            if (kind < 7 && line_buf.size() != 0)
            begin
                case ($urandom_range(0, 4))
                    0: junk = CharMinus;
                    1: junk = CharPoint;
                    2: junk = random_blank();
                    3: junk = CharPlus;
                    default: junk = 8'($urandom_range(1, 255));
                endcase
                pos = $urandom_range(0, line_buf.size() - 1);
                line_buf[pos] = junk;
            end
        end
    endtask

    function automatic logic [4:0] phase_budget(input int p);
        case (p)
            1: return 5'd1;
            2: return 5'd18;
            3: return 5'd31;
            4: return 5'd0;
            5: return 5'($urandom_range(2, 17));
            6: return 5'($urandom_range(0, 31));
            default: return DigitsDefault;
        endcase
    endfunction

    initial
    begin
        int phase_end;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings under the reset budget.
        send_line();
        put_text("\t+0.50");
        line_buf.push_back(CharCr);
        send_line();
        put_text("-.");
        send_line();
        put_text("1.2.");
        send_line();
        line_buf.push_back(8'hFF);
        send_line();
        put_text("9 x");
        send_line();
        put_text("3-");
        send_line();

        // Random phases, each under its own digit budget.
        for (int p = 0; p < PhaseCount; p++)
        begin
            if (p != 0)
                write_budget(phase_budget(p));
            if (p == 2)
            begin
                // Short back-to-back strings while the receiver holds off.
                no_gaps = 1'b1;
                hold_token <= hold_token + 1;
                repeat (12)
                begin
                    push_digits(1, 1'b0);
                    send_line();
                end
                no_gaps = 1'b0;
            end
            phase_end = chars_sent + PhaseChars;
            while (chars_sent < phase_end)
            begin
                build_random_line();
                send_line();
            end
        end

        drain();
        repeat (SettleCycles) @(posedge clk);

        $display("Sent %0d characters; %0d results checked, %0d of them parse errors.",
                 chars_sent, results_checked, error_results);
        $display("Budgets 0, 1, 9, 18, 31 and random values, with digits past the budget.");
        if (mismatch_count == 0 && results_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/dtse_pkg.sv
sv/dtse_step.sv
sv/decimal_text_to_sig_exp.sv
sim/decimal_parse_monitor.sv
sim/decimal_text_to_sig_exp_test.sv
